// ===== rtl/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, tables and parity function for the SEC-DED (22,16) codec.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned NumCheck = 6;
  localparam int unsigned NumSynd  = 22;
  localparam int unsigned NumData  = 16;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_CLEAN = 2'd0,
    STAT_CORR  = 2'd1,
    STAT_MULTI = 2'd2
  } status_e;

  // Two bytes per row: the first masks the first data byte, the second the
  // second data byte. Row 0 yields check bit 5.
  localparam logic [7:0] PMAT [2*NumCheck] = '{
    8'h99, 8'h3c,
    8'h3e, 8'h8a,
    8'hee, 8'h60,
    8'he1, 8'hd1,
    8'h13, 8'hc7,
    8'h44, 8'h3f
  };

  // Entries 0..7 hit second byte bits 0..7, 8..15 first byte bits 0..7,
  // 16..21 check bits 0..5.
  localparam logic [NumCheck-1:0] SYND_TAB [NumSynd] = '{
    6'h07, 6'h13, 6'h23, 6'h31,
    6'h25, 6'h29, 6'h0e, 6'h16,
    6'h26, 6'h1a, 6'h19, 6'h38,
    6'h32, 6'h1c, 6'h0d, 6'h2c,
    6'h01, 6'h02, 6'h04, 6'h08,
    6'h10, 6'h20
  };

  typedef struct packed {
    op_e                 op;
    logic [7:0]          first;
    logic [7:0]          second;
    logic [NumCheck-1:0] rx_check;
    logic [NumCheck-1:0] calc;
  } s1_t;

  typedef struct packed {
    logic [7:0]          first;
    logic [7:0]          second;
    logic [NumData-1:0]  flip;
    logic [NumCheck-1:0] synd;
    status_e             status;
  } s2_t;

  typedef struct packed {
    logic [7:0]          first;
    logic [7:0]          second;
    logic [NumCheck-1:0] check;
    status_e             status;
  } s3_t;

  function automatic logic [NumCheck-1:0] calc_check(input logic [7:0] b0,
                                                     input logic [7:0] b1);
    logic [NumCheck-1:0] c;
    c = '0;
    for (int r = 0; r < NumCheck; r++) begin
      c[NumCheck-1-r] = (^(PMAT[2*r] & b0)) ^ (^(PMAT[2*r+1] & b1));
    end
    return c;
  endfunction

endpackage

// ===== rtl/secded_22_16_codec_unit.sv =====
// ----------------------------------------------------------------------------
// secded_22_16_codec_unit
// Throughput: one transaction per cycle while the sink keeps m_axis_tready
// high, set by three equal register stages (parity, syndrome lookup,
// correction) that each hold one item.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// ----------------------------------------------------------------------------
module secded_22_16_codec_unit import scd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] in_first_byte, [15:8] in_second_byte,
                                     // [21:16] in_check_bits, [23:22] zero
  input  logic        s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_first_byte, [15:8] out_second_byte,
                                     // [21:16] out_check_bits, [23:22] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  op_e  op_in;

  assign op_in = op_e'(s_axis_tuser);

  scd_parity u_parity (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .op_i     (op_in),
    .first_i  (s_axis_tdata[7:0]),
    .second_i (s_axis_tdata[15:8]),
    .check_i  (s_axis_tdata[21:16]),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .data_o   (s1_data)
  );

  scd_locate u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  scd_fix u_fix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (s3_data)
  );

  assign m_axis_tdata = {2'b00, s3_data.check, s3_data.second, s3_data.first};
  assign m_axis_tuser = s3_data.status;

`ifndef SYNTHESIS
  // A corrected word always carries a non-zero syndrome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_CORR |-> m_axis_tdata[21:16] != '0)
    else $error("corrected status with zero syndrome");

  // A multiple-error report never carries a single check-bit syndrome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_MULTI |-> !$onehot0(m_axis_tdata[21:16]))
    else $error("multiple-error status on a check-bit or zero syndrome");

  // At most one data bit is flipped, and only when correcting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid |-> $onehot0(s2_data.flip) &&
                 ((s2_data.flip == '0) || (s2_data.status == STAT_CORR)))
    else $error("illegal correction mask");

  // The last stage drains whenever the sink takes a transaction and nothing follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !s2_valid |=> !m_axis_tvalid)
    else $error("output stage repeated a transaction");
`endif

endmodule

// ===== rtl/scd_parity.sv =====
// ----------------------------------------------------------------------------
// scd_parity
// First pipeline stage: recomputes the six check bits from the data bytes.
// ----------------------------------------------------------------------------
module scd_parity import scd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  op_e        op_i,
  input  logic [7:0] first_i,
  input  logic [7:0] second_i,
  input  logic [5:0] check_i,
  output logic       valid_o,
  input  logic       ready_i,
  output s1_t        data_o
);

  logic valid_q;
  s1_t  data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.op       = op_i;
    data_d.first    = first_i;
    data_d.second   = second_i;
    data_d.rx_check = check_i;
    data_d.calc     = calc_check(first_i, second_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/scd_locate.sv =====
// ----------------------------------------------------------------------------
// scd_locate
// Second pipeline stage: forms the syndrome (the new check bits on encode) and,
// on decode, matches it to the single-error table for the data bit, if any, to flip.
// ----------------------------------------------------------------------------
module scd_locate import scd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic                valid_q;
  s2_t                 data_d, data_q;
  logic [NumCheck-1:0] synd;
  logic [NumSynd-1:0]  hit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    synd = (data_i.op == OP_DECODE) ? (data_i.rx_check ^ data_i.calc) : data_i.calc;
    for (int n = 0; n < NumSynd; n++) begin
      hit[n] = (data_i.op == OP_DECODE) && (synd == SYND_TAB[n]);
    end
    data_d.first  = data_i.first;
    data_d.second = data_i.second;
    data_d.flip   = hit[NumData-1:0];
    data_d.synd   = synd;
    if (data_i.op == OP_ENCODE || synd == '0) begin
      data_d.status = STAT_CLEAN;
    end else if (|hit) begin
      data_d.status = STAT_CORR;
    end else begin
      data_d.status = STAT_MULTI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/scd_fix.sv =====
// ----------------------------------------------------------------------------
// scd_fix
// Third pipeline stage and output register: applies the bit flip to the data.
// ----------------------------------------------------------------------------
module scd_fix import scd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s2_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s3_t  data_o
);

  logic valid_q;
  s3_t  data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.second = data_i.second ^ data_i.flip[7:0];
    data_d.first  = data_i.first ^ data_i.flip[NumData-1:8];
    data_d.check  = data_i.synd;
    data_d.status = data_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
